[hdl/ptt_pkg.sv]
// Shared constants and codes for the periodic callback timer table.
package ptt_pkg;

    // Field and state widths
    localparam int REQ_W    = 2;
    localparam int ID_W     = 8;
    localparam int MS_W     = 16;
    localparam int EV_W     = 2;
    localparam int SLOT_W   = 4;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 48;
    localparam int INTV_W   = 32;
    localparam int MUL_W    = 32;

    // Slot table depth default
    localparam int SLOT_COUNT_DEF = 10;

    // Configuration port
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_TICK_PERIOD = '0;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(3276 * 2);

    // Division by 100 as multiply by reciprocal, then shift
    localparam logic [MUL_W-1:0] CONV_RECIP = 32'd1374389535;
    localparam int CONV_SHIFT = 37;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

    // Result codes
    localparam logic [EV_W-1:0] EV_DONE     = 2'd0;
    localparam logic [EV_W-1:0] EV_FIRED    = 2'd1;
    localparam logic [EV_W-1:0] EV_FULL     = 2'd2;
    localparam logic [EV_W-1:0] EV_NOTFOUND = 2'd3;

endpackage

[hdl/ptt_mul.sv]
// Shared 32x32 multiplier with registered product.
module ptt_mul
(
    input  logic                           clk,
    input  logic [ptt_pkg::MUL_W-1:0]      a,
    input  logic [ptt_pkg::MUL_W-1:0]      b,
    output logic [2*ptt_pkg::MUL_W-1:0]    p
);
    import ptt_pkg::*;

    logic [2*MUL_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
    end

    assign p = p_reg;

endmodule

[hdl/periodic_callback_timer_table.sv]
// Top level of the periodic callback timer table.
//
// Usage: one input channel (in_valid/in_ready) carries requests: tick, add
// periodic handler, remove handler. One output channel (out_valid/out_ready)
// carries results; the final result of each request has last set. The
// APB port holds tick_period at byte address 0; pready is always high.
//
// Steps of each request, N = SLOT_COUNT:
//   tick    : time advance, compare of all N slots, then an emit step for each
//             slot up to the last one that fires, one result per fired slot in
//             slot order; when nothing fires, a check and then one result
//   add     : two passes through the shared multiplier (product, then scale by
//             the reciprocal of 100), a scan for a free slot, then the result
//   remove  : a scan for the slot of that handler, then the result
//   other   : the result
// These steps share the one 48-bit adder and the one multiplier; one request
// is in work at a time. A finished result sits in the output register, so the
// next request is taken while it waits.
// Reset clears time, all slots and the output; tick_period returns to 6552.
// When the receiver stalls, the sequencer holds at the next result to send.
module periodic_callback_timer_table
#(
    parameter int SLOT_COUNT = ptt_pkg::SLOT_COUNT_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ptt_pkg::REQ_W-1:0]       req_type,
    input  logic [ptt_pkg::ID_W-1:0]        handler_id,
    input  logic [ptt_pkg::MS_W-1:0]        interval_ms,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ptt_pkg::EV_W-1:0]        event_res,
    output logic [ptt_pkg::ID_W-1:0]        fired_id,
    output logic [ptt_pkg::SLOT_W-1:0]      slot_index,
    output logic                            last,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptt_pkg::ADDR_W-1:0]      paddr,
    input  logic [ptt_pkg::DATA_W-1:0]      pwdata,
    output logic [ptt_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import ptt_pkg::*;

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TADV  = 4'd1;
    localparam logic [3:0] S_TCMP  = 4'd2;
    localparam logic [3:0] S_TEMIT = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_MUL2  = 4'd5;
    localparam logic [3:0] S_MUL3  = 4'd6;
    localparam logic [3:0] S_AFIND = 4'd7;
    localparam logic [3:0] S_RFIND = 4'd8;
    localparam logic [3:0] S_RESP  = 4'd9;

    logic [3:0]             state_reg;
    logic [IDX_W-1:0]       scan_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [TIME_W-1:0]      time_now_reg;
    logic [ID_W-1:0]        id_reg;
    logic [MS_W-1:0]        ms_reg;
    logic [INTV_W-1:0]      interval_reg;
    logic [SLOT_COUNT-1:0]  fire_mask_reg;

    logic [TIME_W-1:0]      slot_deadline_reg [SLOT_COUNT];
    logic [INTV_W-1:0]      slot_interval_reg [SLOT_COUNT];
    logic                   slot_enabled_reg  [SLOT_COUNT];
    logic [ID_W-1:0]        slot_handler_reg  [SLOT_COUNT];

    logic [EV_W-1:0]        res_ev_reg;
    logic [ID_W-1:0]        res_id_reg;
    logic [SLOT_W-1:0]      res_slot_reg;

    logic                   out_valid_reg;
    logic [EV_W-1:0]        out_ev_reg;
    logic [ID_W-1:0]        out_id_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic                   out_last_reg;

    logic                   out_free;
    logic                   out_load;
    logic                   cfg_wr;
    logic                   higher_any;
    logic [TIME_W-1:0]      add_a;
    logic [TIME_W-1:0]      add_b;
    logic [TIME_W-1:0]      add_sum;
    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [2*MUL_W-1:0]     mul_p;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_TICK_PERIOD);
    assign prdata = (paddr[ADDR_W-1:2] == REG_TICK_PERIOD) ?
                    DATA_W'(period_reg) : '0;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign event_res  = out_ev_reg;
    assign fired_id   = out_id_reg;
    assign slot_index = out_slot_reg;
    assign last       = out_last_reg;

    // a new result enters the output register this cycle
    assign out_load = out_free &&
                      ((state_reg == S_RESP) ||
                       ((state_reg == S_TEMIT) && fire_mask_reg[scan_reg]));

    // shared 48-bit adder
    always_comb
    begin
        case (state_reg)
            S_TADV:
            begin
                add_a = time_now_reg;
                add_b = TIME_W'(period_reg);
            end
            S_TEMIT:
            begin
                add_a = slot_deadline_reg[scan_reg];
                add_b = TIME_W'(slot_interval_reg[scan_reg]);
            end
            default:
            begin
                add_a = time_now_reg;
                add_b = TIME_W'(interval_reg);
            end
        endcase
        add_sum = add_a + add_b;
    end

    // any fired slot left above the current one
    always_comb
    begin
        higher_any = 1'b0;
        for (int j = 0; j < SLOT_COUNT; j++)
        begin
            if ((IDX_W'(j) > scan_reg) && fire_mask_reg[j])
            begin
                higher_any = 1'b1;
            end
        end
    end

    // first pass: ms * period; second pass: scale by reciprocal of 100
    assign mul_a = (state_reg == S_MUL1) ? MUL_W'(ms_reg) : mul_p[MUL_W-1:0];
    assign mul_b = (state_reg == S_MUL1) ? MUL_W'(period_reg) : CONV_RECIP;

    ptt_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            period_reg    <= PERIOD_RESET;
            time_now_reg  <= '0;
            id_reg        <= '0;
            ms_reg        <= '0;
            interval_reg  <= '0;
            fire_mask_reg <= '0;
            res_ev_reg    <= EV_DONE;
            res_id_reg    <= '0;
            res_slot_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= EV_DONE;
            out_id_reg    <= '0;
            out_slot_reg  <= '0;
            out_last_reg  <= 1'b0;
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slot_deadline_reg[k] <= '0;
                slot_interval_reg[k] <= '0;
                slot_enabled_reg[k]  <= 1'b0;
                slot_handler_reg[k]  <= '0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                period_reg <= pwdata[PERIOD_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        id_reg   <= handler_id;
                        ms_reg   <= interval_ms;
                        scan_reg <= '0;
                        case (req_type)
                            REQ_TICK:   state_reg <= S_TADV;
                            REQ_ADD:    state_reg <= S_MUL1;
                            REQ_REMOVE: state_reg <= S_RFIND;
                            default:
                            begin
                                res_ev_reg   <= EV_DONE;
                                res_id_reg   <= '0;
                                res_slot_reg <= '0;
                                state_reg    <= S_RESP;
                            end
                        endcase
                    end
                end

                S_TADV:
                begin
                    time_now_reg <= add_sum;
                    scan_reg     <= '0;
                    state_reg    <= S_TCMP;
                end

                S_TCMP:
                begin
                    fire_mask_reg[scan_reg] <= slot_enabled_reg[scan_reg] &&
                                               (slot_deadline_reg[scan_reg] <= time_now_reg);
                    if (scan_reg == IDX_LAST)
                    begin
                        scan_reg  <= '0;
                        state_reg <= S_TEMIT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_TEMIT:
                begin
                    if (fire_mask_reg == '0)
                    begin
                        res_ev_reg   <= EV_DONE;
                        res_id_reg   <= '0;
                        res_slot_reg <= '0;
                        state_reg    <= S_RESP;
                    end
                    else if (fire_mask_reg[scan_reg])
                    begin
                        // hold here until the output register frees up
                        if (out_free)
                        begin
                            out_ev_reg    <= EV_FIRED;
                            out_id_reg    <= slot_handler_reg[scan_reg];
                            out_slot_reg  <= SLOT_W'(scan_reg);
                            out_last_reg  <= !higher_any;
                            slot_deadline_reg[scan_reg] <= add_sum;
                            if (higher_any)
                            begin
                                scan_reg <= scan_reg + 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end

                S_MUL2:
                begin
                    state_reg <= S_MUL3;
                end

                S_MUL3:
                begin
                    interval_reg <= INTV_W'(mul_p >> CONV_SHIFT);
                    scan_reg     <= '0;
                    state_reg    <= S_AFIND;
                end

                S_AFIND:
                begin
                    if ((slot_deadline_reg[scan_reg] == '0) && !slot_enabled_reg[scan_reg])
                    begin
                        slot_interval_reg[scan_reg] <= interval_reg;
                        slot_handler_reg[scan_reg]  <= id_reg;
                        slot_deadline_reg[scan_reg] <= add_sum;
                        slot_enabled_reg[scan_reg]  <= 1'b1;
                        res_ev_reg   <= EV_DONE;
                        res_id_reg   <= id_reg;
                        res_slot_reg <= SLOT_W'(scan_reg);
                        state_reg    <= S_RESP;
                    end
                    else if (scan_reg == IDX_LAST)
                    begin
                        res_ev_reg   <= EV_FULL;
                        res_id_reg   <= '0;
                        res_slot_reg <= '0;
                        state_reg    <= S_RESP;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_RFIND:
                begin
                    if (slot_handler_reg[scan_reg] == id_reg)
                    begin
                        slot_interval_reg[scan_reg] <= '0;
                        slot_handler_reg[scan_reg]  <= '0;
                        slot_deadline_reg[scan_reg] <= '0;
                        slot_enabled_reg[scan_reg]  <= 1'b0;
                        res_ev_reg   <= EV_DONE;
                        res_id_reg   <= id_reg;
                        res_slot_reg <= SLOT_W'(scan_reg);
                        state_reg    <= S_RESP;
                    end
                    else if (scan_reg == IDX_LAST)
                    begin
                        res_ev_reg   <= EV_NOTFOUND;
                        res_id_reg   <= '0;
                        res_slot_reg <= '0;
                        state_reg    <= S_RESP;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end

                S_RESP:
                begin
                    if (out_free)
                    begin
                        out_ev_reg    <= res_ev_reg;
                        out_id_reg    <= res_id_reg;
                        out_slot_reg  <= res_slot_reg;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hdl/ptt_checker.sv]
// Port-level checker for the periodic callback timer table, with its bind.
module ptt_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ptt_pkg::EV_W-1:0]     event_res,
    input logic [ptt_pkg::ID_W-1:0]     fired_id,
    input logic [ptt_pkg::SLOT_W-1:0]   slot_index,
    input logic                         last
);
    import ptt_pkg::*;

    // one request in work at a time: drop ready after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready still high after request transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(event_res) && $stable(fired_id) &&
             $stable(slot_index) && $stable(last)))
        else $error("result changed while stalled");

    // full and not-found are single results
    a_fail_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_FULL || event_res == EV_NOTFOUND)) |-> last)
        else $error("failure result not marked last");

    a_fail_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (event_res == EV_FULL || event_res == EV_NOTFOUND)) |->
            (fired_id == '0 && slot_index == '0))
        else $error("failure result names a slot");

endmodule

bind periodic_callback_timer_table ptt_checker u_ptt_checker (.*);
